FILE: hdl/wpp_pkg.sv
// shared constants and types of the window peak-to-peak channel selector
`timescale 1ns / 1ps
`default_nettype none
package wpp_pkg;

	localparam int NUM_CH       = 4;
	localparam int SAMPLE_W     = 8;
	localparam int WINDOW_DEPTH = 32;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int MEM_W        = NUM_CH * SAMPLE_W;
	localparam int BEST_W       = $clog2(NUM_CH);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index taken from paddr[2]
	localparam logic REG_DETECT_THRESHOLD = 1'b0;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(100);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] chan_vec_t;

	typedef struct packed {
		logic      valid;
		chan_vec_t mag;
	} span_res_t;

endpackage
`default_nettype wire

FILE: hdl/window_peak_to_peak_channel_select.sv
// top level of the four-channel sliding window peak-to-peak selector
`timescale 1ns / 1ps
`default_nettype none
// Each accepted frame carries one 8-bit sample for each of four channels. The
// samples are stored in a 32-entry window memory (one word holds all four
// channels) and the block then walks the valid part of the window through the
// memory's single read port, one entry per cycle, tracking min and max per
// channel. The scan covers the N samples in the window after the write (1 up
// to 32), and no new frame is taken until the scan of the last one is done and
// its result has been taken into the output register.
// The result reports max minus min of each channel, the strongest channel (ties
// to the lower index) and a detect flag when that magnitude is strictly above
// detect_threshold (APB register at byte address 0, reset 100). A finished
// result sits in an output register, so a stalled output does not hold up the
// next frame's scan. No clearing pass is needed after reset.
module window_peak_to_peak_channel_select (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input transaction
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [wpp_pkg::SAMPLE_W-1:0]  sample_ch1,
	input  wire logic [wpp_pkg::SAMPLE_W-1:0]  sample_ch2,
	input  wire logic [wpp_pkg::SAMPLE_W-1:0]  sample_ch3,
	input  wire logic [wpp_pkg::SAMPLE_W-1:0]  sample_ch4,
	// result transaction
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [wpp_pkg::SAMPLE_W-1:0]       mag_ch1,
	output logic [wpp_pkg::SAMPLE_W-1:0]       mag_ch2,
	output logic [wpp_pkg::SAMPLE_W-1:0]       mag_ch3,
	output logic [wpp_pkg::SAMPLE_W-1:0]       mag_ch4,
	output logic [wpp_pkg::BEST_W-1:0]         best_channel,
	output logic                               detected,
	// apb register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wpp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [wpp_pkg::PDATA_W-1:0]   pwdata,
	output logic      [wpp_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import wpp_pkg::*;

	sample_t             threshold_q;
	chan_vec_t           samples;
	span_res_t           span;
	logic                res_take;
	logic [BEST_W-1:0]   sel_best;
	logic                sel_detected;
	logic                reg_hit;

	// register file: one threshold register, index taken from the word address
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_DETECT_THRESHOLD);
	assign prdata  = reg_hit ? PDATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			threshold_q <= pwdata[SAMPLE_W-1:0];
		end
	end

	// channel one sits in the lowest byte of the memory word
	assign samples[0] = sample_ch1;
	assign samples[1] = sample_ch2;
	assign samples[2] = sample_ch3;
	assign samples[3] = sample_ch4;

	wpp_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.samples  (samples),
		.res      (span),
		.res_take (res_take)
	);

	wpp_select u_select (
		.mag       (span.mag),
		.threshold (threshold_q),
		.best      (sel_best),
		.detected  (sel_detected)
	);

	// output register: loads when empty or being drained this cycle
	assign res_take = span.valid && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			mag_ch1      <= span.mag[0];
			mag_ch2      <= span.mag[1];
			mag_ch3      <= span.mag[2];
			mag_ch4      <= span.mag[3];
			best_channel <= sel_best;
			detected     <= sel_detected;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wpp_ram.sv
// single write port, single registered read port memory
`timescale 1ns / 1ps
`default_nettype none
module wpp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wpp_scan.sv
// window store and min/max scan sequencer
`timescale 1ns / 1ps
`default_nettype none
module wpp_scan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire wpp_pkg::chan_vec_t samples,
	output wpp_pkg::span_res_t      res,
	input  wire logic               res_take
);
	import wpp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] rd_idx_q;
	logic [FILL_W-1:0] rd_idx_nxt;
	logic              rd_vld_s1;
	chan_vec_t         min_q;
	chan_vec_t         max_q;
	logic [MEM_W-1:0]  rdata;
	logic              accept;
	logic              rd_en;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign rd_en      = (state_q == ST_READ);
	assign rd_idx_nxt = rd_idx_q + FILL_W'(1);

	wpp_ram #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (slot_q),
		.wdata (samples),
		.re    (rd_en),
		.raddr (rd_idx_q[SLOT_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slot_q    <= '0;
			fill_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						slot_q   <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ?
							'0 : slot_q + SLOT_W'(1);
						fill_q   <= (fill_q == FILL_W'(WINDOW_DEPTH)) ?
							fill_q : fill_q + FILL_W'(1);
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_nxt;
					if (rd_idx_nxt == fill_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// running min/max per channel, restarted on each frame
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (accept) begin
				min_q[ch] <= '1;
				max_q[ch] <= '0;
			end else if (rd_vld_s1) begin
				if (rdata[ch*SAMPLE_W +: SAMPLE_W] < min_q[ch]) begin
					min_q[ch] <= rdata[ch*SAMPLE_W +: SAMPLE_W];
				end
				if (rdata[ch*SAMPLE_W +: SAMPLE_W] > max_q[ch]) begin
					max_q[ch] <= rdata[ch*SAMPLE_W +: SAMPLE_W];
				end
			end
		end
	end

	always_comb begin
		res.valid = (state_q == ST_DONE);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			res.mag[ch] = max_q[ch] - min_q[ch];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wpp_select.sv
// strongest channel pick and threshold compare
`timescale 1ns / 1ps
`default_nettype none
module wpp_select (
	input  wire wpp_pkg::chan_vec_t        mag,
	input  wire wpp_pkg::sample_t          threshold,
	output logic [wpp_pkg::BEST_W-1:0]     best,
	output logic                           detected
);
	import wpp_pkg::*;

	sample_t best_mag;

	// strict greater keeps the lower channel on a tie
	always_comb begin
		best     = '0;
		best_mag = mag[0];
		for (int ch = 1; ch < NUM_CH; ch++) begin
			if (mag[ch] > best_mag) begin
				best     = BEST_W'(ch);
				best_mag = mag[ch];
			end
		end
		detected = (best_mag > threshold);
	end

endmodule
`default_nettype wire

FILE: tb/sv/window_peak_to_peak_channel_select_tb.sv
// self-checking testbench of the four-channel sliding window peak-to-peak selector
`timescale 1ns / 1ps
`default_nettype none
module window_peak_to_peak_channel_select_tb;
	import wpp_pkg::*;

	// register map: the threshold register and one address that maps to nothing
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = {REG_DETECT_THRESHOLD, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = {~REG_DETECT_THRESHOLD, 2'b00};

	localparam int RANDOM_PER_PHASE = 115;
	localparam int HOLD_OFF_AFTER   = 150;
	localparam int HOLD_OFF_CYCLES  = 600;
	localparam int SETTLE_CYCLES    = 4;
	// long enough for a full window scan to finish, so this covers any straggler
	localparam int DRAIN_CYCLES     = 50;

	// one result transaction as the block should report it
	typedef struct packed {
		chan_vec_t           mag;
		logic [BEST_W-1:0]   best;
		logic                det;
	} span_verdict_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		chan_vec_t      smp;
		logic           typed;
		span_verdict_t  want;
	} directed_row_t;

	// shapes of random frame segments
	typedef enum int {GEN_NOISE, GEN_WILD, GEN_TIED, GEN_STEADY, GEN_RAILS} gen_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_W-1:0] sample_ch1 = '0;
	logic [SAMPLE_W-1:0] sample_ch2 = '0;
	logic [SAMPLE_W-1:0] sample_ch3 = '0;
	logic [SAMPLE_W-1:0] sample_ch4 = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [SAMPLE_W-1:0] mag_ch1;
	logic [SAMPLE_W-1:0] mag_ch2;
	logic [SAMPLE_W-1:0] mag_ch3;
	logic [SAMPLE_W-1:0] mag_ch4;
	logic [BEST_W-1:0] best_channel;
	logic detected;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// predictor copy of the window, its pointers and the threshold
	sample_t win_store [NUM_CH][WINDOW_DEPTH];
	int slot_model = 0;
	int fill_model = 0;
	sample_t thr_model = THRESHOLD_RESET;

	// results still owed by the block, oldest first
	span_verdict_t pending_spans[$];
	directed_row_t directed_rows[$];

	int mismatch_count = 0;
	int results_seen = 0;

	// random segment state
	gen_mode_t seg_mode = GEN_NOISE;
	int seg_left = 0;
	int seg_base [NUM_CH];
	int seg_amp [NUM_CH];
	// sender stretch with no gaps
	int calm_left = 0;

	window_peak_to_peak_channel_select i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_ch1   (sample_ch1),
		.sample_ch2   (sample_ch2),
		.sample_ch3   (sample_ch3),
		.sample_ch4   (sample_ch4),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mag_ch1      (mag_ch1),
		.mag_ch2      (mag_ch2),
		.mag_ch3      (mag_ch3),
		.mag_ch4      (mag_ch4),
		.best_channel (best_channel),
		.detected     (detected),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#8_000_000;
		$display("window_peak_to_peak_channel_select_tb: errors");
		$finish;
	end

	// channel one sits in the low byte
	function automatic chan_vec_t frame(input int a, input int b, input int c, input int d);
		frame = {d[SAMPLE_W-1:0], c[SAMPLE_W-1:0], b[SAMPLE_W-1:0], a[SAMPLE_W-1:0]};
	endfunction

	function automatic span_verdict_t spans(input int a, input int b, input int c, input int d,
			input int best, input logic det);
		spans.mag  = frame(a, b, c, d);
		spans.best = best[BEST_W-1:0];
		spans.det  = det;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch %s: expected %0d, got %0d at %0t ns", what, want, got, $time);
		end
	endtask

	// store the frame, then span every channel over the valid part of the window
	// and rank the channels
	task automatic absorb_frame(input chan_vec_t smp, output span_verdict_t res);
		int ch;
		int i;
		sample_t lo;
		sample_t hi;
		sample_t top;
		for (ch = 0; ch < NUM_CH; ch++) begin
			win_store[ch][slot_model] = smp[ch];
		end
		slot_model = (slot_model == WINDOW_DEPTH - 1) ? 0 : slot_model + 1;
		if (fill_model < WINDOW_DEPTH) begin
			fill_model++;
		end
		for (ch = 0; ch < NUM_CH; ch++) begin
			lo = '1;
			hi = '0;
			// entries past fill_model were never written and are never looked at
			for (i = 0; i < fill_model; i++) begin
				if (win_store[ch][i] < lo) lo = win_store[ch][i];
				if (win_store[ch][i] > hi) hi = win_store[ch][i];
			end
			res.mag[ch] = hi - lo;
		end
		// strict compare keeps the lower channel on a tie
		res.best = '0;
		top = res.mag[0];
		for (ch = 1; ch < NUM_CH; ch++) begin
			if (res.mag[ch] > top) begin
				res.best = ch[BEST_W-1:0];
				top = res.mag[ch];
			end
		end
		res.det = (top > thr_model);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic int sender_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left = $urandom_range(20, 60);
		end
		return pick_gap();
	endfunction

	// offer one input transaction, hold it until accepted, then book the result
	task automatic offer_frame(input chan_vec_t smp, input logic typed, input span_verdict_t typed_want);
		span_verdict_t predicted;
		int gap;
		in_valid <= 1'b1;
		{sample_ch4, sample_ch3, sample_ch2, sample_ch1} <= smp;
		do @(posedge clk); while (!in_ready);
		absorb_frame(smp, predicted);
		pending_spans.push_back(typed ? typed_want : predicted);
		// with no gap valid simply stays up for the next transaction
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// quiet the input and wait until every owed result has come out
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup phase, access phase, then back to idle
	task automatic program_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// only the threshold address is mapped, anything else is dropped
		if (addr[PADDR_W-1] == REG_DETECT_THRESHOLD) begin
			thr_model = word[SAMPLE_W-1:0];
		end
		@(posedge clk);
	endtask

	// apb read of the threshold, compared with the predictor copy
	task automatic confirm_threshold();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_THRESHOLD;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(thr_model)) begin
			report_mismatch("detect_threshold readback", thr_model, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int noisy_sample(input int ch);
		int v;
		v = int'($urandom_range(0, 2 * seg_amp[ch]));
		v = seg_base[ch] + v - seg_amp[ch];
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v;
	endfunction

	// frames come in segments of one shape so the windows build real spans
	task automatic next_random_frame(output chan_vec_t smp);
		int ch;
		int r;
		int v;
		if (seg_left == 0) begin
			r = $urandom_range(0, 9);
			seg_mode = (r < 5) ? GEN_NOISE : (r == 5) ? GEN_WILD : (r < 8) ? GEN_TIED :
				(r == 8) ? GEN_STEADY : GEN_RAILS;
			seg_left = $urandom_range(4, 60);
			for (ch = 0; ch < NUM_CH; ch++) begin
				seg_base[ch] = $urandom_range(0, 255);
				seg_amp[ch] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
					$urandom_range(0, 40);
			end
		end
		seg_left--;
		for (ch = 0; ch < NUM_CH; ch++) begin
			case (seg_mode)
				GEN_WILD: v = $urandom_range(0, 255);
				GEN_STEADY: v = seg_base[ch];
				GEN_RAILS: v = $urandom_range(0, 1) ? 255 : 0;
				// identical samples on every channel of the frame
				GEN_TIED: v = (ch == 0) ? noisy_sample(0) : int'(smp[0]);
				default: v = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : noisy_sample(ch);
			endcase
			smp[ch] = v[SAMPLE_W-1:0];
		end
	endtask

	task automatic run_random_frames(input int count);
		chan_vec_t smp;
		int k;
		for (k = 0; k < count; k++) begin
			next_random_frame(smp);
			offer_frame(smp, 1'b0, '0);
		end
	endtask

	// result side: compare every accepted result transaction with the oldest owed one
	always @(posedge clk) begin : check_results
		span_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_spans.size() == 0) begin
				report_mismatch("result with none owed, pending count", 0, 1);
			end else begin
				want = pending_spans.pop_front();
				if (mag_ch1 !== want.mag[0]) report_mismatch("mag_ch1", want.mag[0], mag_ch1);
				if (mag_ch2 !== want.mag[1]) report_mismatch("mag_ch2", want.mag[1], mag_ch2);
				if (mag_ch3 !== want.mag[2]) report_mismatch("mag_ch3", want.mag[2], mag_ch3);
				if (mag_ch4 !== want.mag[3]) report_mismatch("mag_ch4", want.mag[3], mag_ch4);
				if (best_channel !== want.best) begin
					report_mismatch("best_channel", want.best, best_channel);
				end
				if (detected !== want.det) report_mismatch("detected", want.det, detected);
			end
		end
	end

	// receiver: random ready pattern plus one long hold-off to back up the input
	initial begin
		int run;
		int gap;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_OFF_AFTER) begin
				// sender keeps offering, so the block fills and drops in_ready
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// main sequence: reset, directed table, then random phases over several thresholds
	initial begin
		int idx;
		logic [PDATA_W-1:0] thr_words [5];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the threshold
		confirm_threshold();

		// threshold is 100 here; the first row is the single sample case
		directed_rows.push_back('{smp: frame(10, 20, 30, 40), typed: 1'b1,
			want: spans(0, 0, 0, 0, 0, 1'b0)});
		// magnitude equal to the threshold does not detect
		directed_rows.push_back('{smp: frame(10, 20, 30, 140), typed: 1'b1,
			want: spans(0, 0, 0, 100, 3, 1'b0)});
		// one above the threshold detects
		directed_rows.push_back('{smp: frame(10, 20, 30, 141), typed: 1'b1,
			want: spans(0, 0, 0, 101, 3, 1'b1)});
		// tie between channels two and four goes to two
		directed_rows.push_back('{smp: frame(10, 121, 30, 40), typed: 1'b1,
			want: spans(0, 101, 0, 101, 1, 1'b1)});
		directed_rows.push_back('{smp: frame(0, 20, 30, 40), typed: 1'b1,
			want: spans(10, 101, 0, 101, 1, 1'b1)});
		// full scale sample on every channel
		directed_rows.push_back('{smp: frame(255, 255, 255, 255), typed: 1'b1,
			want: spans(255, 235, 225, 215, 0, 1'b1)});
		// alternating bit patterns and near-rail values, checked by the predictor
		directed_rows.push_back('{smp: frame(8'hAA, 8'h55, 8'hFF, 8'h00), typed: 1'b0, want: '0});
		directed_rows.push_back('{smp: frame(8'h55, 8'hAA, 8'h00, 8'hFF), typed: 1'b0, want: '0});
		directed_rows.push_back('{smp: frame(128, 127, 1, 254), typed: 1'b0, want: '0});
		directed_rows.push_back('{smp: frame(0, 0, 0, 0), typed: 1'b0, want: '0});
		directed_rows.push_back('{smp: frame(255, 0, 255, 0), typed: 1'b0, want: '0});
		for (idx = 0; idx < directed_rows.size(); idx++) begin
			offer_frame(directed_rows[idx].smp, directed_rows[idx].typed, directed_rows[idx].want);
		end
		finish_phase();

		// lowest threshold, plus a write to an unmapped address that must not land
		program_register(ADDR_THRESHOLD, '0);
		program_register(ADDR_UNMAPPED, PDATA_W'(255));
		confirm_threshold();
		run_random_frames(RANDOM_PER_PHASE);
		finish_phase();

		// highest threshold, one below it, one above zero, then random words
		thr_words[0] = PDATA_W'(255);
		thr_words[1] = PDATA_W'(254);
		thr_words[2] = PDATA_W'(1);
		thr_words[3] = $urandom();
		thr_words[4] = $urandom();
		for (idx = 0; idx < 5; idx++) begin
			program_register(ADDR_THRESHOLD, thr_words[idx]);
			confirm_threshold();
			run_random_frames(RANDOM_PER_PHASE);
			finish_phase();
		end

		// let any stray result transaction show up before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("window_peak_to_peak_channel_select_tb: clean");
		end else begin
			$display("window_peak_to_peak_channel_select_tb: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
